### rtl/iiel_pkg.sv
`timescale 1ns / 1ps
// iiel_pkg: shared types and constants for the indexed insert/erase list
// depends on nothing; used by iiel_cell and indexed_insert_erase_list
package iiel_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int ELEM_BITS_DEFAULT = 32;
  localparam int LIMIT_BITS        = 5;
  localparam int INDEX_BITS        = 5;
  localparam int VALUE_BITS        = 32;
  localparam int LENGTH_BITS       = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BOUND = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2
  } cell_cmd_t;

  typedef struct packed {
    op_t                   op;
    logic [INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0] value;
  } in_beat_t;

  typedef struct packed {
    status_t                status;
    logic [VALUE_BITS-1:0]  read_value;
    logic [LENGTH_BITS-1:0] length;
  } out_beat_t;

endpackage

### rtl/iiel_cell.sv
`timescale 1ns / 1ps
// iiel_cell: one element slot of the list, shifts with its neighbors
// depends on iiel_pkg
module iiel_cell #(
  parameter int DEPTH     = iiel_pkg::DEPTH_DEFAULT,
  parameter int ELEM_BITS = iiel_pkg::ELEM_BITS_DEFAULT,
  parameter int POS       = 0
) (
  input  logic                         clk,
  input  iiel_pkg::cell_cmd_t          cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   pos,
  input  logic [ELEM_BITS-1:0]         value,
  input  logic [ELEM_BITS-1:0]         lower,
  input  logic [ELEM_BITS-1:0]         upper,
  output logic [ELEM_BITS-1:0]         data,
  output logic [ELEM_BITS-1:0]         tap
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] MY_POS = CW'(POS);

  always_ff @(posedge clk) begin
    unique case (cmd)
      iiel_pkg::CMD_INSERT: begin
        if (pos == MY_POS) begin
          data <= value;
        end else if (MY_POS > pos) begin
          data <= lower;
        end
      end
      iiel_pkg::CMD_ERASE: begin
        if (MY_POS >= pos) begin
          data <= upper;
        end
      end
      iiel_pkg::CMD_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  assign tap = (pos == MY_POS) ? data : '0;

endmodule

### rtl/indexed_insert_erase_list.sv
`timescale 1ns / 1ps
// indexed_insert_erase_list: ordered list held in a row of shifting cells
// depends on iiel_pkg and iiel_cell
//
// Requests arrive on the in channel (in_valid / in_stall / in_beat) and each
// one gives exactly one result beat on the out channel (out_valid / out_stall
// / out_beat): status, read value and the length after the request.
// A request is decoded and applied in the cycle it is accepted; the cells at
// and above the index take a neighbor's value or the new one at that edge,
// so insert and erase are done there. The result is in the output register
// from the next cycle; throughput is one request per cycle while out is taken.
// A new request is taken while a result is being taken; while the receiver
// stalls, the result holds and in_stall rises until it is taken.
// cfg_write with cfg_data sets the capacity limit (capped at DEPTH); the user
// must write it only while no request is in flight; this is not enforced.
// Reset empties the list, sets the limit to 16 and drops out_valid. Cell
// contents are not cleared; only cells below the length are ever read.
module indexed_insert_erase_list #(
  parameter int DEPTH     = iiel_pkg::DEPTH_DEFAULT,
  parameter int ELEM_BITS = iiel_pkg::ELEM_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  iiel_pkg::in_beat_t                in_beat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output iiel_pkg::out_beat_t               out_beat,
  input  logic                              cfg_write,
  input  logic [iiel_pkg::LIMIT_BITS-1:0]   cfg_data
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int XW = (CW > iiel_pkg::INDEX_BITS) ? CW : iiel_pkg::INDEX_BITS;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic [CW-1:0]                   count;
  logic [CW-1:0]                   count_next;
  logic [iiel_pkg::LIMIT_BITS-1:0] limit;
  logic [XW-1:0]                   lim_eff;
  logic [XW-1:0]                   count_x;
  logic [XW-1:0]                   index_x;
  logic                            full;
  logic                            accept;
  logic                            read_ok;
  iiel_pkg::status_t               status_c;
  iiel_pkg::cell_cmd_t             cmd_c;
  iiel_pkg::cell_cmd_t             cmd;
  logic [CW-1:0]                   pos;
  logic [ELEM_BITS-1:0]            elem_in;
  logic [ELEM_BITS-1:0]            cell_data [DEPTH];
  logic [ELEM_BITS-1:0]            cell_tap  [DEPTH];
  logic [ELEM_BITS-1:0]            rd_or;

  assign accept  = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign count_x = XW'(count);
  assign index_x = XW'(in_beat.index);
  assign lim_eff = (XW'(limit) > DEPTH_X) ? DEPTH_X : XW'(limit);
  assign full    = count_x >= lim_eff;
  assign elem_in = ELEM_BITS'(in_beat.value);

  always_comb begin
    status_c   = iiel_pkg::ST_OK;
    cmd_c      = iiel_pkg::CMD_HOLD;
    pos        = CW'(in_beat.index);
    count_next = count;
    read_ok    = 1'b0;
    unique case (in_beat.op)
      iiel_pkg::OP_PUSH: begin
        pos = count;
        if (full) begin
          status_c = iiel_pkg::ST_FULL;
        end else begin
          cmd_c      = iiel_pkg::CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      iiel_pkg::OP_POP: begin
        if (count == '0) begin
          status_c = iiel_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      iiel_pkg::OP_INSERT: begin
        if (index_x > count_x) begin
          status_c = iiel_pkg::ST_BOUND;
        end else if (full) begin
          status_c = iiel_pkg::ST_FULL;
        end else begin
          cmd_c      = iiel_pkg::CMD_INSERT;
          count_next = count + 1'b1;
        end
      end
      iiel_pkg::OP_ERASE: begin
        if (index_x >= count_x) begin
          status_c = iiel_pkg::ST_BOUND;
        end else begin
          cmd_c      = iiel_pkg::CMD_ERASE;
          count_next = count - 1'b1;
        end
      end
      iiel_pkg::OP_READ: begin
        if (index_x >= count_x) begin
          status_c = iiel_pkg::ST_BOUND;
        end else begin
          read_ok = 1'b1;
        end
      end
      iiel_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd = accept ? cmd_c : iiel_pkg::CMD_HOLD;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_BITS-1:0] lower;
    logic [ELEM_BITS-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    iiel_cell #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS),
      .POS       (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .pos   (pos),
      .value (elem_in),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[i]),
      .tap   (cell_tap[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      limit     <= iiel_pkg::LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat.status     <= status_c;
      out_beat.read_value <= read_ok ? iiel_pkg::VALUE_BITS'(rd_or) : '0;
      out_beat.length     <= iiel_pkg::LENGTH_BITS'(count_next);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= DEPTH_X)
    else $error("list length beyond depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (out_beat.length == iiel_pkg::LENGTH_BITS'(count)))
    else $error("result beat missing or length mismatch");

  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && (status_c != iiel_pkg::ST_OK) |=> $stable(count))
    else $error("failed request changed the length");

  a_growth_limit: assert property (@(posedge clk) disable iff (rst)
    accept && (count_next > count) |-> (count_x < lim_eff))
    else $error("list grew past the capacity limit");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    accept && !read_ok |=> (out_beat.read_value == '0))
    else $error("read value set on a non-read result");

endmodule
